[src/online_norm_forward_top_assert.svh]
// online_norm_forward_top_assert.svh: assertion macros for the online normalization block.
// Expects clk and arst_n in the scope of each use.
`ifndef ONLINE_NORM_FORWARD_TOP_ASSERT_SVH
`define ONLINE_NORM_FORWARD_TOP_ASSERT_SVH
// same-cycle implication
`define ONF_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define ONF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[src/onf_pkg.sv]
// onf_pkg.sv: constants, codes and types of the online normalization block.
// No dependencies.
package onf_pkg;
	localparam int CHANNELS    = 64;
	localparam int CH_W        = $clog2(CHANNELS);
	localparam int MAX_SPATIAL = 4096;
	localparam int A_W         = 58;
	localparam int B_W         = 33;
	localparam int P_W         = A_W + B_W;
	localparam int CNT_W       = $clog2(A_W);
	localparam logic [31:0] VAR_ONE = 32'h0100_0000;

	localparam logic [1:0] CFG_ALPHA   = 2'd0;
	localparam logic [1:0] CFG_EPSILON = 2'd1;
	localparam logic [1:0] CFG_COUNT   = 2'd2;

	typedef enum logic [2:0] {
		OP_MUL  = 3'b001,
		OP_DIV  = 3'b010,
		OP_SQRT = 3'b100
	} alu_op_t;

	typedef struct packed {
		logic           start;
		alu_op_t        op;
		logic [A_W-1:0] a;
		logic [B_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic           busy;
		logic           done;
		logic [P_W-1:0] res;
	} alu_rsp_t;
endpackage

[src/onf_ram.sv]
// onf_ram.sv: generic single-port-write, registered-read RAM.
// No dependencies.
module onf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[src/onf_alu.sv]
// onf_alu.sv: shared iterative unit: shift-add multiply, restoring divide, digit sqrt.
// Depends on onf_pkg.
module onf_alu import onf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);
	alu_op_t          op_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [P_W-1:0]   acc_q;
	logic [P_W-1:0]   a_q;
	logic [B_W-1:0]   b_q;
	logic [B_W:0]     rem_q;
	logic [B_W:0]     dt;
	logic [B_W:0]     ds;
	logic             dge;
	logic [B_W:0]     st;
	logic [B_W:0]     strial;
	logic [B_W:0]     ss;
	logic             sge;

	always_comb begin
		dt     = {rem_q[B_W-1:0], a_q[A_W-1]};
		dge    = dt >= {1'b0, b_q};
		ds     = dt - {1'b0, b_q};
		st     = {rem_q[B_W-2:0], a_q[A_W-1 -: 2]};
		strial = {acc_q[B_W-2:0], 2'b01};
		sge    = st >= strial;
		ss     = st - strial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				case (req.op)
					OP_MUL:  cnt_q <= CNT_W'(B_W - 1);
					OP_DIV:  cnt_q <= CNT_W'(A_W - 1);
					OP_SQRT: cnt_q <= CNT_W'(A_W / 2 - 1);
					default: cnt_q <= '0;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			rem_q <= '0;
			b_q   <= req.b;
			a_q   <= P_W'(req.a);
		end else if (busy_q) begin
			case (op_q)
				OP_MUL: begin
					if (b_q[0]) begin
						acc_q <= acc_q + a_q;
					end
					a_q <= a_q << 1;
					b_q <= b_q >> 1;
				end
				OP_DIV: begin
					acc_q <= {acc_q[P_W-2:0], dge};
					rem_q <= dge ? ds : dt;
					a_q   <= a_q << 1;
				end
				OP_SQRT: begin
					acc_q <= {acc_q[P_W-2:0], sge};
					rem_q <= sge ? ss : st;
					a_q   <= a_q << 2;
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.res  = acc_q;
endmodule

[src/online_norm_forward_top.sv]
// online_norm_forward_top: online normalization forward pass, one element at a time.
// Each element takes a sqrt, a divide, a sqrt and a multiply; a flagged last element then
// adds a statistics update of two divides and eight multiplies before the next is taken.
// in_stall holds off new elements until idle; multiply, divide and sqrt use one shared ALU.
// Reset: asynchronous active low; statistics read as mean 0, variance 1.0 until written.
// Depends on onf_pkg, onf_alu, onf_ram and the assertion macro header.
module online_norm_forward_top import onf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample_value,
	input  logic [5:0]         channel,
	input  logic               last_of_channel,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] normalized,
	output logic [15:0]        scale_used,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [24:0]        cfg_data
);
	typedef enum logic [17:0] {
		S_IDLE = 18'h00001,
		S_RD   = 18'h00002,
		S_SCL  = 18'h00004,
		S_DIV  = 18'h00008,
		S_RSQ  = 18'h00010,
		S_NRM  = 18'h00020,
		S_OUT  = 18'h00040,
		S_MEAN = 18'h00080,
		S_SS   = 18'h00100,
		S_NSQ  = 18'h00200,
		S_VAR  = 18'h00400,
		S_D2   = 18'h00800,
		S_PHI  = 18'h01000,
		S_PLO  = 18'h02000,
		S_BA   = 18'h04000,
		S_BV   = 18'h08000,
		S_DM   = 18'h10000,
		S_WR   = 18'h20000
	} state_t;

	state_t             state_q;
	logic               started_q;
	logic [15:0]        alpha_q;
	logic [24:0]        eps_q;
	logic [12:0]        count_q;
	logic [CHANNELS-1:0] vld_q;
	logic               out_valid_q;
	logic signed [15:0] normalized_q;
	logic [15:0]        scale_used_q;

	logic signed [15:0] x_q;
	logic [CH_W-1:0]    ch_q;
	logic               last_q;
	logic [31:0]        mean_q;
	logic [31:0]        var_q;
	logic [15:0]        scale_q;
	logic [A_W-1:0]     qd_q;
	logic [31:0]        recip_q;
	logic signed [15:0] norm_q;
	logic [27:0]        sum_q;
	logic [43:0]        sq_q;
	logic [31:0]        m_q;
	logic [55:0]        ss_q;
	logic [56:0]        nsq_q;
	logic [31:0]        v_q;
	logic [41:0]        d2_q;
	logic [52:0]        phi_q;
	logic [50:0]        plo_q;
	logic [47:0]        ba_q;
	logic [48:0]        bv_q;
	logic [49:0]        dm_q;

	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	logic               accept;
	logic               calc;
	logic               ram_we;
	logic [63:0]        ram_rdata;

	logic [32:0]        veps;
	logic [32:0]        diff;
	logic [32:0]        dmag;
	logic [12:0]        n_eff;
	logic [25:0]        n2;
	logic [27:0]        smag;
	logic [57:0]        num;
	logic               num_nonpos;
	logic [32:0]        delta;
	logic [32:0]        dmagd;
	logic [16:0]        oma;
	logic [32:0]        coef;
	logic [38:0]        rnd;
	logic [40:0]        mq;
	logic [40:0]        cross_term;
	logic [33:0]        blend;
	logic [41:0]        nv_sum;
	logic [31:0]        nv;
	logic signed [50:0] sdm;
	logic [31:0]        nm;
	logic signed [31:0] xsq;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = state_q != S_IDLE;
	assign ram_we   = state_q == S_WR;

	always_comb begin
		veps       = {1'b0, var_q} + 33'(eps_q);
		diff       = {{5{x_q[15]}}, x_q, 12'b0} - {mean_q[31], mean_q};
		dmag       = diff[32] ? (33'd0 - diff) : diff;
		if (count_q == 13'd0) begin
			n_eff = 13'd1;
		end else if (count_q > 13'(MAX_SPATIAL)) begin
			n_eff = 13'(MAX_SPATIAL);
		end else begin
			n_eff = count_q;
		end
		n2         = n_eff * n_eff;
		smag       = sum_q[27] ? (28'd0 - sum_q) : sum_q;
		num        = 58'(nsq_q) - 58'(ss_q);
		num_nonpos = num[57] || (num == 58'd0);
		delta      = {m_q[31], m_q} - {mean_q[31], mean_q};
		dmagd      = delta[32] ? (33'd0 - delta) : delta;
		oma        = 17'h10000 - 17'(alpha_q);
		coef       = 33'(alpha_q * oma);
		rnd        = alu_rsp.res[66:28] + 39'(alu_rsp.res[27]);
		mq         = alu_rsp.res[40:0];
		cross_term = 41'((53'(phi_q) + 53'(plo_q[50:20])) >> 12);
		blend      = 34'((50'(ba_q) + 50'(bv_q)) >> 16);
		nv_sum     = 42'(blend) + 42'(cross_term);
		nv         = (nv_sum[41:32] != '0) ? 32'hFFFF_FFFF : nv_sum[31:0];
		sdm        = delta[32] ? (51'sd0 - $signed({1'b0, dm_q})) : $signed({1'b0, dm_q});
		nm         = mean_q + 32'(sdm >>> 16);
		xsq        = x_q * x_q;
	end

	always_comb begin
		calc          = 1'b1;
		alu_req.op    = OP_MUL;
		alu_req.a     = '0;
		alu_req.b     = '0;
		case (state_q)
			S_SCL: begin
				alu_req.op = OP_SQRT;
				alu_req.a  = A_W'(veps);
			end
			S_DIV: begin
				alu_req.op = OP_DIV;
				alu_req.a  = A_W'(1) << 56;
				alu_req.b  = veps;
			end
			S_RSQ: begin
				alu_req.op = OP_SQRT;
				alu_req.a  = qd_q;
			end
			S_NRM: begin
				alu_req.a = A_W'(dmag);
				alu_req.b = B_W'(recip_q);
			end
			S_MEAN: begin
				alu_req.op = OP_DIV;
				alu_req.a  = A_W'({smag, 12'b0}) + A_W'(n_eff >> 1);
				alu_req.b  = B_W'(n_eff);
			end
			S_SS: begin
				alu_req.a = A_W'(smag);
				alu_req.b = B_W'(smag);
			end
			S_NSQ: begin
				alu_req.a = A_W'(sq_q);
				alu_req.b = B_W'(n_eff);
			end
			S_VAR: begin
				alu_req.op = OP_DIV;
				alu_req.a  = num + A_W'(n2 >> 1);
				alu_req.b  = B_W'(n2);
			end
			S_D2: begin
				alu_req.a = A_W'(dmagd);
				alu_req.b = dmagd;
			end
			S_PHI: begin
				alu_req.a = A_W'(d2_q[41:20]);
				alu_req.b = coef;
			end
			S_PLO: begin
				alu_req.a = A_W'(d2_q[19:0]);
				alu_req.b = coef;
			end
			S_BA: begin
				alu_req.a = A_W'(var_q);
				alu_req.b = B_W'(alpha_q);
			end
			S_BV: begin
				alu_req.a = A_W'(v_q);
				alu_req.b = B_W'(oma);
			end
			S_DM: begin
				alu_req.a = A_W'(dmagd);
				alu_req.b = B_W'(oma);
			end
			default: begin
				calc = 1'b0;
			end
		endcase
		alu_req.start = calc && !started_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 16'd65470;
			eps_q   <= 25'd17;
			count_q <= 13'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ALPHA:   alpha_q <= cfg_data[15:0];
				CFG_EPSILON: eps_q   <= cfg_data;
				CFG_COUNT:   count_q <= cfg_data[12:0];
				default:     alpha_q <= alpha_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			started_q   <= 1'b0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
			sum_q       <= '0;
			sq_q        <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (calc) begin
				if (!started_q) begin
					started_q <= 1'b1;
				end else if (alu_rsp.done) begin
					started_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: if (accept) begin
					state_q <= S_RD;
				end
				S_RD: begin
					sum_q   <= sum_q + 28'(x_q);
					sq_q    <= sq_q + 44'(unsigned'(xsq));
					state_q <= S_SCL;
				end
				S_SCL:  if (started_q && alu_rsp.done) state_q <= S_DIV;
				S_DIV:  if (started_q && alu_rsp.done) state_q <= S_RSQ;
				S_RSQ:  if (started_q && alu_rsp.done) state_q <= S_NRM;
				S_NRM:  if (started_q && alu_rsp.done) state_q <= S_OUT;
				S_OUT: if (!out_valid_q || !out_stall) begin
					out_valid_q <= 1'b1;
					state_q     <= last_q ? S_MEAN : S_IDLE;
				end
				S_MEAN: if (started_q && alu_rsp.done) state_q <= S_SS;
				S_SS:   if (started_q && alu_rsp.done) state_q <= S_NSQ;
				S_NSQ:  if (started_q && alu_rsp.done) state_q <= S_VAR;
				S_VAR:  if (started_q && alu_rsp.done) state_q <= S_D2;
				S_D2:   if (started_q && alu_rsp.done) state_q <= S_PHI;
				S_PHI:  if (started_q && alu_rsp.done) state_q <= S_PLO;
				S_PLO:  if (started_q && alu_rsp.done) state_q <= S_BA;
				S_BA:   if (started_q && alu_rsp.done) state_q <= S_BV;
				S_BV:   if (started_q && alu_rsp.done) state_q <= S_DM;
				S_DM:   if (started_q && alu_rsp.done) state_q <= S_WR;
				S_WR: begin
					vld_q[ch_q] <= 1'b1;
					sum_q       <= '0;
					sq_q        <= '0;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= sample_value;
			ch_q   <= channel[CH_W-1:0];
			last_q <= last_of_channel;
		end
		if (state_q == S_RD) begin
			mean_q <= vld_q[ch_q] ? ram_rdata[63:32] : 32'd0;
			var_q  <= vld_q[ch_q] ? ram_rdata[31:0] : VAR_ONE;
		end
		if (state_q == S_OUT && (!out_valid_q || !out_stall)) begin
			normalized_q <= norm_q;
			scale_used_q <= scale_q;
		end
		if (started_q && alu_rsp.done) begin
			case (state_q)
				S_SCL: scale_q <= (alu_rsp.res[28:16] != '0) ? 16'hFFFF : alu_rsp.res[15:0];
				S_DIV: qd_q <= alu_rsp.res[A_W-1:0];
				S_RSQ: recip_q <= (veps == 33'd0) ? 32'hFFFF_FFFF : alu_rsp.res[31:0];
				S_NRM: begin
					if (diff[32]) begin
						norm_q <= (rnd > 39'd32768) ? -16'sd32768 : 16'(39'd0 - rnd);
					end else begin
						norm_q <= (rnd > 39'd32767) ? 16'sd32767 : 16'(rnd);
					end
				end
				S_MEAN: begin
					if (sum_q[27]) begin
						m_q <= (mq > 41'h0_8000_0000) ? 32'h8000_0000 : 32'(41'd0 - mq);
					end else begin
						m_q <= (mq > 41'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mq[31:0];
					end
				end
				S_SS:  ss_q <= alu_rsp.res[55:0];
				S_NSQ: nsq_q <= alu_rsp.res[56:0];
				S_VAR: begin
					if (num_nonpos) begin
						v_q <= 32'd0;
					end else begin
						v_q <= (alu_rsp.res[57:32] != '0) ? 32'hFFFF_FFFF : alu_rsp.res[31:0];
					end
				end
				S_D2:  d2_q <= alu_rsp.res[65:24];
				S_PHI: phi_q <= alu_rsp.res[52:0];
				S_PLO: plo_q <= alu_rsp.res[50:0];
				S_BA:  ba_q <= alu_rsp.res[47:0];
				S_BV:  bv_q <= alu_rsp.res[48:0];
				S_DM:  dm_q <= alu_rsp.res[49:0];
				default: ;
			endcase
		end
	end

	onf_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	onf_ram #(
		.WIDTH (64),
		.DEPTH (CHANNELS)
	) u_stats (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ch_q),
		.wdata ({nm, nv}),
		.re    (accept),
		.raddr (channel[CH_W-1:0]),
		.rdata (ram_rdata)
	);

	assign out_valid  = out_valid_q;
	assign normalized = normalized_q;
	assign scale_used = scale_used_q;

`include "online_norm_forward_top_assert.svh"
	`ONF_ASSERT_NEXT(a_accept_read, accept, state_q == S_RD && !started_q, "request not read")
	`ONF_ASSERT_SAME(a_alu_free, alu_req.start, !alu_rsp.busy, "alu restarted while busy")
	`ONF_ASSERT_SAME(a_done_owned, alu_rsp.done, started_q && calc, "alu done unclaimed")
	`ONF_ASSERT_SAME(a_write_last, ram_we, last_q, "stats written without last flag")
endmodule
